@@ hw/rtl/plq_pkg.sv @@
// plq_pkg: sizes, status codes and controller/datapath command types of the
// priority linked queue. No dependencies.
`default_nettype none

package plq_pkg;

  localparam int NUM_THREADS   = 16;
  localparam int NUM_QUEUES    = 2;
  localparam int PRIORITY_BITS = 8;

  localparam int NUM_ENTRIES = NUM_THREADS + NUM_QUEUES;
  localparam int LINK_W      = $clog2(NUM_ENTRIES);
  localparam int KIDX_W      = $clog2(NUM_THREADS);
  localparam int STEP_W      = $clog2(NUM_THREADS + 1);
  localparam int KEY_W       = PRIORITY_BITS;

  // fixed field widths of the channels
  localparam int Q_W      = 1;
  localparam int TH_W     = 4;
  localparam int PRI_W    = 8;
  localparam int STATUS_W = 2;
  localparam int HEAD_W   = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_ENQUEUED = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic    capture;      // load request beat
    logic    rd_check;     // read first links of the request
    logic    chk_enq;      // write key, start walk at tail
    logic    walk_step;    // step back one link
    logic    deq_head;     // latch head, read its successor
    logic    rd_succ;      // read successor of insert point
    logic    wr_a;         // first link write pair
    logic    wr_b;         // second link write pair
    logic    status_load;
    status_t status_code;
    logic    out_load;     // move result into output register
  } plq_cmd_t;

  typedef struct packed {
    logic kind;
    logic req_bad;    // queue or thread out of range
    logic queued;     // thread already linked
    logic prev_stop;  // prev link read is a root or out of range
    logic walk_cont;  // new key sorts before entry at pos
    logic deq_empty;
  } plq_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/plq_in_if.sv @@
// plq_in_if: request channel of the priority linked queue.
// Depends on plq_pkg for field widths.
`default_nettype none

interface plq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [plq_pkg::Q_W-1:0]     queue_sel;
  logic [plq_pkg::TH_W-1:0]    thread_id;
  logic [plq_pkg::PRI_W-1:0]   priority_req;

  modport source (output valid, kind, queue_sel, thread_id, priority_req, input ready);
  modport sink   (input valid, kind, queue_sel, thread_id, priority_req, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/plq_out_if.sv @@
// plq_out_if: response channel of the priority linked queue.
// Depends on plq_pkg for field widths.
`default_nettype none

interface plq_out_if;
  logic                          valid;
  logic                          ready;
  logic [plq_pkg::STATUS_W-1:0]  status;
  logic [plq_pkg::HEAD_W-1:0]    head_thread;

  modport source (output valid, status, head_thread, input ready);
  modport sink   (input valid, status, head_thread, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/priority_linked_queue.sv @@
// priority_linked_queue: top level, joins the sequencer and the datapath.
// Depends on plq_pkg, plq_in_if, plq_out_if, plq_ctrl and plq_dpath.
`default_nettype none

// Several sorted thread queues share one table of doubly linked entries, one
// per thread plus one root per queue. An enqueue beat (kind 0) links a thread
// into the selected queue behind every queued thread whose key is not greater,
// so equal keys leave first in, first out; a thread already queued anywhere,
// or out of range, is ignored with status 1. A dequeue beat (kind 1) unlinks
// the head of the queue and returns it with status 2, or returns status 3 and
// head_thread 16 when the queue is empty. Every request beat gives exactly one
// response beat. One operation is in flight at a time. An enqueue walks
// backward from the tail until it reaches the root or stops at an entry
// whose key is not greater, stepping over the queued entries in between
// (0 to 15 of them), one per cycle, limited by the single read port of the
// key and prev-link tables. The next request beat can be accepted at the
// edge after the response register loads. The response register lets the
// next request be accepted while a response still waits. After reset all
// queues are empty at once; no clearing pass is needed.

module priority_linked_queue (
  input  wire logic   clk,
  input  wire logic   rst,
  plq_in_if.sink      req,
  plq_out_if.source   rsp
);

  plq_pkg::plq_cmd_t   cmd;
  plq_pkg::plq_stat_t  stat;

  // sequencer: handshakes and one state per table access
  plq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath: link and key tables, walk position, response register
  plq_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (req.kind),
    .in_queue_sel    (req.queue_sel),
    .in_thread_id    (req.thread_id),
    .in_priority_req (req.priority_req),
    .status          (rsp.status),
    .head_thread     (rsp.head_thread)
  );

endmodule

`default_nettype wire

@@ hw/rtl/plq_ctrl.sv @@
// plq_ctrl: sequencer of the priority linked queue, one operation at a time.
// Depends on plq_pkg for command and status structs.
`default_nettype none

module plq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output plq_pkg::plq_cmd_t        cmd,
  input  wire plq_pkg::plq_stat_t  stat
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_WALK   = 8'b0000_1000,
    S_SUCC   = 8'b0001_0000,
    S_WR_A   = 8'b0010_0000,
    S_WR_B   = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        if (stat.req_bad) begin
          cmd.status_load = 1'b1;
          cmd.status_code = stat.kind ? plq_pkg::ST_EMPTY : plq_pkg::ST_IGNORED;
          state_next      = S_FINISH;
        end else begin
          cmd.rd_check = 1'b1;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.kind) begin
          if (stat.deq_empty) begin
            cmd.status_load = 1'b1;
            cmd.status_code = plq_pkg::ST_EMPTY;
            state_next      = S_FINISH;
          end else begin
            cmd.deq_head = 1'b1;
            state_next   = S_WR_A;
          end
        end else if (stat.queued) begin
          cmd.status_load = 1'b1;
          cmd.status_code = plq_pkg::ST_IGNORED;
          state_next      = S_FINISH;
        end else begin
          cmd.chk_enq = 1'b1;
          state_next  = stat.prev_stop ? S_SUCC : S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_cont) begin
          cmd.walk_step = 1'b1;
          state_next    = stat.prev_stop ? S_SUCC : S_WALK;
        end else begin
          state_next = S_SUCC;
        end
      end
      S_SUCC: begin
        cmd.rd_succ = 1'b1;
        state_next  = S_WR_A;
      end
      S_WR_A: begin
        cmd.wr_a   = 1'b1;
        state_next = S_WR_B;
      end
      S_WR_B: begin
        cmd.wr_b        = 1'b1;
        cmd.status_load = 1'b1;
        cmd.status_code = stat.kind ? plq_pkg::ST_DEQUEUED : plq_pkg::ST_ENQUEUED;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/plq_dpath.sv @@
// plq_dpath: link tables, key table, walk registers and result registers.
// Depends on plq_pkg; driven by plq_ctrl commands.
`default_nettype none

module plq_dpath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire plq_pkg::plq_cmd_t            cmd,
  output plq_pkg::plq_stat_t                stat,
  input  wire logic                         in_kind,
  input  wire logic [plq_pkg::Q_W-1:0]      in_queue_sel,
  input  wire logic [plq_pkg::TH_W-1:0]     in_thread_id,
  input  wire logic [plq_pkg::PRI_W-1:0]    in_priority_req,
  output logic [plq_pkg::STATUS_W-1:0]      status,
  output logic [plq_pkg::HEAD_W-1:0]        head_thread
);

  localparam int LW = plq_pkg::LINK_W;
  localparam int NE = plq_pkg::NUM_ENTRIES;
  localparam int NT = plq_pkg::NUM_THREADS;

  // request
  logic                          kind_r;
  logic [plq_pkg::Q_W-1:0]       q_r;
  logic [plq_pkg::TH_W-1:0]      th_r;
  logic [plq_pkg::KEY_W-1:0]     key_r;

  // walk and link state
  logic [LW-1:0]                 pos, succ_r, head;
  logic [plq_pkg::STEP_W-1:0]    steps;
  plq_pkg::status_t              res_status;
  logic [plq_pkg::HEAD_W-1:0]    res_head;

  // link memories, valid bit clear means entry links to itself
  logic [LW-1:0]                 next_mem [NE];
  logic [LW-1:0]                 prev_mem [NE];
  logic [NE-1:0]                 next_vld, prev_vld;
  logic [plq_pkg::KEY_W-1:0]     key_mem  [NT];

  logic [LW-1:0]                 next_q, next_aq, prev_q, prev_aq;
  logic                          next_vq, prev_vq;
  logic [plq_pkg::KEY_W-1:0]     key_q;
  logic [LW-1:0]                 next_rd, prev_rd;

  logic [LW-1:0]                 root, th_l, pos_c, succ_c;
  logic                          next_re, prev_re, key_re;
  logic [LW-1:0]                 next_ra, prev_ra;
  logic [plq_pkg::KIDX_W-1:0]    key_ra;
  logic                          next_we, prev_we;
  logic [LW-1:0]                 next_wa, next_wd, prev_wa, prev_wd;

  assign root    = LW'(NT) + LW'(q_r);
  assign th_l    = LW'(th_r);
  assign next_rd = next_vq ? next_q : next_aq;
  assign prev_rd = prev_vq ? prev_q : prev_aq;
  assign pos_c   = (32'(pos) >= NE) ? root : pos;
  assign succ_c  = (32'(next_rd) >= NE) ? root : next_rd;

  // status to controller
  always_comb begin
    stat.kind      = kind_r;
    stat.req_bad   = (32'(q_r) >= plq_pkg::NUM_QUEUES) || (!kind_r && (32'(th_r) >= NT));
    stat.queued    = (next_rd != th_l);
    stat.prev_stop = (prev_rd == root) || (32'(prev_rd) >= NT);
    stat.walk_cont = (32'(steps) < NT) && (key_r < key_q);
    stat.deq_empty = (next_rd == root) || (32'(next_rd) >= NT);
  end

  // read ports
  assign next_re = cmd.rd_check | cmd.deq_head | cmd.rd_succ;
  assign prev_re = cmd.rd_check | cmd.chk_enq | cmd.walk_step;
  assign key_re  = cmd.chk_enq | cmd.walk_step;
  assign key_ra  = prev_rd[plq_pkg::KIDX_W-1:0];

  always_comb begin
    priority if (cmd.rd_check) begin
      next_ra = kind_r ? root : th_l;
    end else if (cmd.deq_head) begin
      next_ra = next_rd;
    end else begin
      next_ra = pos_c;
    end
    prev_ra = cmd.rd_check ? root : prev_rd;
  end

  // write ports, two pairs per operation
  always_comb begin
    next_we = cmd.wr_a | cmd.wr_b;
    prev_we = cmd.wr_a | cmd.wr_b;
    if (cmd.wr_a) begin
      next_wa = kind_r ? root : th_l;
      next_wd = succ_c;
      prev_wa = kind_r ? succ_c : th_l;
      prev_wd = kind_r ? root : pos_c;
    end else begin
      next_wa = kind_r ? head : pos_c;
      next_wd = kind_r ? head : th_l;
      prev_wa = kind_r ? head : succ_r;
      prev_wd = kind_r ? head : th_l;
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (cmd.chk_enq) begin
      key_mem[th_r[plq_pkg::KIDX_W-1:0]] <= key_r;
    end
    if (next_re) begin
      next_q  <= next_mem[next_ra];
      next_vq <= next_vld[next_ra];
      next_aq <= next_ra;
    end
    if (prev_re) begin
      prev_q  <= prev_mem[prev_ra];
      prev_vq <= prev_vld[prev_ra];
      prev_aq <= prev_ra;
    end
    if (key_re) begin
      key_q <= key_mem[key_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_vld <= '0;
      prev_vld <= '0;
    end else begin
      if (next_we) begin
        next_vld[next_wa] <= 1'b1;
      end
      if (prev_we) begin
        prev_vld[prev_wa] <= 1'b1;
      end
    end
  end

  // request, walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      q_r    <= in_queue_sel;
      th_r   <= in_thread_id;
      key_r  <= in_priority_req[plq_pkg::KEY_W-1:0];
    end
    if (cmd.chk_enq) begin
      pos   <= prev_rd;
      steps <= '0;
    end else if (cmd.walk_step) begin
      pos   <= prev_rd;
      steps <= steps + 1'b1;
    end
    if (cmd.deq_head) begin
      head <= next_rd;
    end
    if (cmd.wr_a) begin
      succ_r <= succ_c;
    end
    if (cmd.status_load) begin
      res_status <= cmd.status_code;
      res_head   <= (cmd.status_code == plq_pkg::ST_DEQUEUED) ? plq_pkg::HEAD_W'(head)
                                                              : plq_pkg::HEAD_W'(NT);
    end
    if (cmd.out_load) begin
      status      <= res_status;
      head_thread <= res_head;
    end
  end

endmodule

`default_nettype wire
